>>> sv/mie_pkg.sv
// Shared types and constants for the MIPS32 integer execute block.
`timescale 1ns / 1ps
package mie_pkg;

  localparam int DMEM_WORDS_DEF = 1024;
  localparam logic [31:0] PC_START_RST  = 32'h0040_0000;
  localparam logic [31:0] DATA_BASE_RST = 32'h1000_0000;
  localparam logic [4:0]  RA_IDX = 5'd31;

  // configuration register indexes
  localparam logic CFG_PC_START  = 1'b0;
  localparam logic CFG_DATA_BASE = 1'b1;

  // item op codes
  localparam logic OP_EXEC    = 1'b0;
  localparam logic OP_PRELOAD = 1'b1;

  // primary opcodes
  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_REGIMM  = 6'h01;
  localparam logic [5:0] OPC_J       = 6'h02;
  localparam logic [5:0] OPC_JAL     = 6'h03;
  localparam logic [5:0] OPC_BEQ     = 6'h04;
  localparam logic [5:0] OPC_BNE     = 6'h05;
  localparam logic [5:0] OPC_BLEZ    = 6'h06;
  localparam logic [5:0] OPC_BGTZ    = 6'h07;
  localparam logic [5:0] OPC_ADDI    = 6'h08;
  localparam logic [5:0] OPC_ADDIU   = 6'h09;
  localparam logic [5:0] OPC_SLTI    = 6'h0A;
  localparam logic [5:0] OPC_SLTIU   = 6'h0B;
  localparam logic [5:0] OPC_ANDI    = 6'h0C;
  localparam logic [5:0] OPC_ORI     = 6'h0D;
  localparam logic [5:0] OPC_XORI    = 6'h0E;
  localparam logic [5:0] OPC_LUI     = 6'h0F;
  localparam logic [5:0] OPC_LB      = 6'h20;
  localparam logic [5:0] OPC_LH      = 6'h21;
  localparam logic [5:0] OPC_LW      = 6'h23;
  localparam logic [5:0] OPC_LBU     = 6'h24;
  localparam logic [5:0] OPC_LHU     = 6'h25;
  localparam logic [5:0] OPC_SB      = 6'h28;
  localparam logic [5:0] OPC_SH      = 6'h29;
  localparam logic [5:0] OPC_SW      = 6'h2B;

  // SPECIAL funct codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNSUP = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_ADDR  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    CL_ALU, CL_SHIFT, CL_MFHI, CL_MFLO, CL_MTHI, CL_MTLO, CL_MULT, CL_DIV,
    CL_JUMP, CL_BRANCH, CL_IMM, CL_LOAD, CL_STORE, CL_PRELOAD, CL_UNSUP
  } iclass_t;

  typedef struct packed {
    iclass_t     cls;
    logic [31:0] instr;
    logic [31:0] mem_addr;
    logic [31:0] mem_data;
  } qitem_t;

endpackage

>>> sv/mips32_integer_execute.sv
// Top level of the MIPS32 integer execute block.
`timescale 1ns / 1ps
// Executes one MIPS32 instruction (or one data memory preload) per item against an
// internal register file, HI/LO and data memory; one result per item, in order.
// An item runs through a four-step sequencer (take from queue, read registers,
// execute, finish): loads, stores and multiplies add one step (one data memory
// read or one registered multiply), divides add a one-bit-per-cycle restoring
// divider; unsupported items, bad addresses and divides by zero go straight from
// execute to finish. A result that is not popped holds the sequencer in its
// finish step. Items are worked one at a time; a two-entry input queue and a result
// register keep both sides moving. After reset the data memory is zeroed word by
// word, during which full stays high.
module mips32_integer_execute #(
  parameter int DMEM_WORDS = mie_pkg::DMEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [31:0] instr,
  input  logic [31:0] mem_addr,
  input  logic [31:0] mem_data,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] next_pc,
  output logic        reg_written,
  output logic [4:0]  reg_index,
  output logic [31:0] reg_value,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import mie_pkg::*;

  logic   q_valid, q_pop, busy;
  qitem_t q_item;

  mie_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op), .instr(instr),
    .mem_addr(mem_addr), .mem_data(mem_data), .busy(busy),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  mie_back #(.DMEM_WORDS(DMEM_WORDS)) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item), .busy(busy),
    .empty(empty), .pop(pop), .next_pc(next_pc), .reg_written(reg_written),
    .reg_index(reg_index), .reg_value(reg_value), .status(status)
  );
endmodule

>>> sv/mie_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/mie_front.sv
// Front end: accepts items, classifies them and holds them in a two-entry queue.
`timescale 1ns / 1ps
module mie_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             op,
  input  logic [31:0]      instr,
  input  logic [31:0]      mem_addr,
  input  logic [31:0]      mem_data,
  input  logic             busy,
  output logic             q_valid,
  input  logic             q_pop,
  output mie_pkg::qitem_t  q_item
);
  import mie_pkg::*;

  qitem_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  iclass_t    cls;
  logic [5:0] opc;
  logic [5:0] fn;
  logic [4:0] rt;

  assign opc = instr[31:26];
  assign fn  = instr[5:0];
  assign rt  = instr[20:16];

  always_comb begin
    cls = CL_UNSUP;
    if (op == OP_PRELOAD) begin
      cls = CL_PRELOAD;
    end else begin
      case (opc)
        OPC_SPECIAL: begin
          case (fn)
            FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
            FN_SLT, FN_SLTU: cls = CL_ALU;
            FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV: cls = CL_SHIFT;
            FN_MFHI: cls = CL_MFHI;
            FN_MFLO: cls = CL_MFLO;
            FN_MTHI: cls = CL_MTHI;
            FN_MTLO: cls = CL_MTLO;
            FN_MULT, FN_MULTU: cls = CL_MULT;
            FN_DIV, FN_DIVU: cls = CL_DIV;
            default: cls = CL_UNSUP;
          endcase
        end
        OPC_REGIMM: cls = (rt inside {5'd0, 5'd1}) ? CL_BRANCH : CL_UNSUP;
        OPC_J, OPC_JAL: cls = CL_JUMP;
        OPC_BEQ, OPC_BNE, OPC_BLEZ, OPC_BGTZ: cls = CL_BRANCH;
        OPC_ADDI, OPC_ADDIU, OPC_SLTI, OPC_SLTIU, OPC_ANDI, OPC_ORI, OPC_XORI,
        OPC_LUI: cls = CL_IMM;
        OPC_LB, OPC_LH, OPC_LW, OPC_LBU, OPC_LHU: cls = CL_LOAD;
        OPC_SB, OPC_SH, OPC_SW: cls = CL_STORE;
        default: cls = CL_UNSUP;
      endcase
    end
  end

  assign full    = (count == 2'd2) || busy;
  assign accept  = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= '{cls: cls, instr: instr, mem_addr: mem_addr, mem_data: mem_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(accept) - 2'(q_pop && q_valid);
    end
  end
endmodule

>>> sv/mie_back.sv
// Back end: register file, HI/LO, data memory, multiply/divide and result register.
`timescale 1ns / 1ps
module mie_back #(
  parameter int DMEM_WORDS = mie_pkg::DMEM_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             q_valid,
  output logic             q_pop,
  input  mie_pkg::qitem_t  q_item,
  output logic             busy,
  output logic             empty,
  input  logic             pop,
  output logic [31:0]      next_pc,
  output logic             reg_written,
  output logic [4:0]       reg_index,
  output logic [31:0]      reg_value,
  output logic [1:0]       status
);
  import mie_pkg::*;

  localparam int AW = $clog2(DMEM_WORDS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_MEM  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t      state, state_next;
  qitem_t      cur;
  logic [31:0] pc, data_base, hi, lo, a, b;
  logic [31:0] gpr_vld;

  // pending result
  logic [31:0] r_npc, r_val, r_hi, r_lo;
  logic        r_wr, r_hilo;
  logic [4:0]  r_idx;
  status_t     r_st;

  // memory access
  logic [AW-1:0] midx;
  logic [1:0]    lane;

  // divider
  logic [32:0] dv_r;
  logic [31:0] dv_q, dv_d;
  logic [4:0]  dv_cnt;
  logic        dv_na, dv_nb;

  // clear pass
  logic          clearing;
  logic [AW-1:0] clr_cnt;

  logic        res_valid;
  logic [31:0] rq_a, rq_b, dm_rdata;
  logic        gpr_we;
  logic        dm_we;
  logic [31:0] dm_wdata;
  logic [AW-1:0] dm_idx;

  // decoded fields of the item at work
  logic [5:0]  opc, fn;
  logic [4:0]  rs, rt, rd, sh, amt;
  logic [15:0] imm;
  logic [31:0] sx, pc4, btgt, ea, off, shv;
  logic        bad, sgn, take, slot_free, fin_wr;
  logic [1:0]  align;
  logic signed [65:0] prod;
  logic [32:0] dv_rs, dv_sub;
  logic        dv_bit;
  logic [31:0] dv_qf, dv_rf;
  logic [31:0] ld_w, ld_v, st_m, st_v;
  logic [4:0]  lsh;

  assign opc  = cur.instr[31:26];
  assign rs   = cur.instr[25:21];
  assign rt   = cur.instr[20:16];
  assign rd   = cur.instr[15:11];
  assign sh   = cur.instr[10:6];
  assign fn   = cur.instr[5:0];
  assign imm  = cur.instr[15:0];
  assign sx   = {{16{imm[15]}}, imm};
  assign pc4  = pc + 32'd4;
  assign btgt = pc4 + {sx[29:0], 2'b00};
  assign amt  = fn[2] ? a[4:0] : sh;
  assign ea   = (cur.cls == CL_PRELOAD) ? cur.mem_addr : a + sx;
  assign off  = ea - data_base;
  assign align = (cur.cls == CL_PRELOAD) ? 2'b11 : opc[1:0];
  assign bad  = ((off[1:0] & align) != 2'b00) || (off[31:2] >= 30'(DMEM_WORDS));
  assign dm_idx = off[AW+1:2];
  assign sgn  = !fn[0];

  always_comb begin
    case (fn[1:0])
      2'b00:   shv = b << amt;
      2'b10:   shv = b >> amt;
      default: shv = 32'($signed(b) >>> amt);
    endcase
  end

  always_comb begin
    case (opc)
      OPC_REGIMM: take = rt[0] ? !a[31] : a[31];
      OPC_BEQ:    take = (a == b);
      OPC_BNE:    take = (a != b);
      OPC_BLEZ:   take = (a == 32'd0) || a[31];
      default:    take = (a != 32'd0) && !a[31];
    endcase
  end

  assign prod = $signed({sgn & a[31], a}) * $signed({sgn & b[31], b});

  // one restoring step a cycle on magnitudes
  assign dv_rs  = {dv_r[31:0], dv_q[31]};
  assign dv_sub = dv_rs - {1'b0, dv_d};
  assign dv_bit = !dv_sub[32];
  assign dv_qf  = {dv_q[30:0], dv_bit};
  assign dv_rf  = dv_bit ? dv_sub[31:0] : dv_rs[31:0];

  assign lsh  = {lane, 3'b000};
  assign ld_w = dm_rdata >> lsh;
  always_comb begin
    case (opc)
      OPC_LB:  ld_v = {{24{ld_w[7]}}, ld_w[7:0]};
      OPC_LBU: ld_v = {24'd0, ld_w[7:0]};
      OPC_LH:  ld_v = {{16{ld_w[15]}}, ld_w[15:0]};
      OPC_LHU: ld_v = {16'd0, ld_w[15:0]};
      default: ld_v = ld_w;
    endcase
    case (opc[1:0])
      2'b00:   st_m = 32'h0000_00FF;
      2'b01:   st_m = 32'h0000_FFFF;
      default: st_m = 32'hFFFF_FFFF;
    endcase
    st_v = (dm_rdata & ~(st_m << lsh)) | ((b & st_m) << lsh);
  end

  assign slot_free = !res_valid || pop;
  assign fin_wr    = r_wr && (r_idx != 5'd0);
  assign gpr_we    = (state == S_DONE) && slot_free && fin_wr;
  assign q_pop     = (state == S_IDLE) && q_valid && !clearing;
  assign busy      = clearing;
  assign empty     = !res_valid;

  always_comb begin
    dm_we    = 1'b0;
    dm_wdata = st_v;
    if (state == S_EXEC && cur.cls == CL_PRELOAD && !bad) begin
      dm_we    = 1'b1;
      dm_wdata = cur.mem_data;
    end else if (state == S_MEM && cur.cls == CL_STORE) begin
      dm_we = 1'b1;
    end
  end

  mie_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_a (
    .clk(clk), .we(gpr_we), .waddr(r_idx), .wdata(r_val),
    .raddr(q_item.instr[25:21]), .rdata(rq_a)
  );
  mie_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_b (
    .clk(clk), .we(gpr_we), .waddr(r_idx), .wdata(r_val),
    .raddr(q_item.instr[20:16]), .rdata(rq_b)
  );
  mie_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
    .clk(clk),
    .we(clearing || dm_we),
    .waddr(clearing ? clr_cnt : (state == S_EXEC ? dm_idx : midx)),
    .wdata(clearing ? 32'd0 : dm_wdata),
    .raddr(dm_idx),
    .rdata(dm_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_pop) state_next = S_READ;
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        case (cur.cls)
          CL_MULT:           state_next = S_MUL;
          CL_DIV:            state_next = (b == 32'd0) ? S_DONE : S_DIV;
          CL_LOAD, CL_STORE: state_next = bad ? S_DONE : S_MEM;
          default:           state_next = S_DONE;
        endcase
      end
      S_MUL:  state_next = S_DONE;
      S_DIV:  if (dv_cnt == 5'd31) state_next = S_DONE;
      S_MEM:  state_next = S_DONE;
      S_DONE: if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= PC_START_RST;
      data_base <= DATA_BASE_RST;
      hi        <= 32'd0;
      lo        <= 32'd0;
      gpr_vld   <= 32'd0;
      res_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == AW'(DMEM_WORDS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_PC_START) begin
          pc <= cfg_data;
        end else begin
          data_base <= cfg_data;
        end
      end
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      if (state == S_DONE && slot_free) begin
        res_valid <= 1'b1;
        pc        <= r_npc;
        if (gpr_we) begin
          gpr_vld[r_idx] <= 1'b1;
        end
        if (r_hilo) begin
          hi <= r_hi;
          lo <= r_lo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (state == S_DONE && slot_free) begin
      next_pc     <= r_npc;
      reg_written <= fin_wr;
      reg_index   <= fin_wr ? r_idx : 5'd0;
      reg_value   <= fin_wr ? r_val : 32'd0;
      status      <= r_st;
    end
    case (state)
      S_READ: begin
        a <= gpr_vld[rs] ? rq_a : 32'd0;
        b <= gpr_vld[rt] ? rq_b : 32'd0;
      end
      S_EXEC: begin
        r_npc  <= pc4;
        r_wr   <= 1'b0;
        r_idx  <= rd;
        r_val  <= 32'd0;
        r_st   <= ST_OK;
        r_hilo <= 1'b0;
        r_hi   <= hi;
        r_lo   <= lo;
        midx   <= dm_idx;
        lane   <= off[1:0];
        case (cur.cls)
          CL_ALU: begin
            r_wr <= 1'b1;
            case (fn)
              FN_ADD, FN_ADDU: r_val <= a + b;
              FN_SUB, FN_SUBU: r_val <= a - b;
              FN_AND:  r_val <= a & b;
              FN_OR:   r_val <= a | b;
              FN_XOR:  r_val <= a ^ b;
              FN_NOR:  r_val <= ~(a | b);
              FN_SLT:  r_val <= {31'd0, $signed(a) < $signed(b)};
              default: r_val <= {31'd0, a < b};
            endcase
          end
          CL_SHIFT: begin
            r_wr  <= 1'b1;
            r_val <= shv;
          end
          CL_MFHI: begin
            r_wr  <= 1'b1;
            r_val <= hi;
          end
          CL_MFLO: begin
            r_wr  <= 1'b1;
            r_val <= lo;
          end
          CL_MTHI: begin
            r_hilo <= 1'b1;
            r_hi   <= a;
          end
          CL_MTLO: begin
            r_hilo <= 1'b1;
            r_lo   <= a;
          end
          CL_DIV: begin
            if (b == 32'd0) begin
              r_st <= ST_DIVZ;
            end
            dv_na  <= sgn & a[31];
            dv_nb  <= sgn & b[31];
            dv_q   <= (sgn & a[31]) ? 32'd0 - a : a;
            dv_d   <= (sgn & b[31]) ? 32'd0 - b : b;
            dv_r   <= 33'd0;
            dv_cnt <= 5'd0;
          end
          CL_JUMP: begin
            r_npc <= {pc4[31:28], cur.instr[25:0], 2'b00};
            r_wr  <= (opc == OPC_JAL);
            r_idx <= RA_IDX;
            r_val <= pc4;
          end
          CL_BRANCH: begin
            if (take) begin
              r_npc <= btgt;
            end
          end
          CL_IMM: begin
            r_wr  <= 1'b1;
            r_idx <= rt;
            case (opc)
              OPC_ADDI, OPC_ADDIU: r_val <= a + sx;
              OPC_SLTI:  r_val <= {31'd0, $signed(a) < $signed(sx)};
              OPC_SLTIU: r_val <= {31'd0, a < sx};
              OPC_ANDI:  r_val <= a & {16'd0, imm};
              OPC_ORI:   r_val <= a | {16'd0, imm};
              OPC_XORI:  r_val <= a ^ {16'd0, imm};
              default:   r_val <= {imm, 16'd0};
            endcase
          end
          CL_LOAD, CL_STORE: begin
            r_idx <= rt;
            if (bad) begin
              r_st <= ST_ADDR;
            end
          end
          CL_PRELOAD: begin
            r_npc <= pc;
            if (bad) begin
              r_st <= ST_ADDR;
            end
          end
          CL_MULT: ;
          default: r_st <= ST_UNSUP;
        endcase
      end
      S_MUL: begin
        r_hilo <= 1'b1;
        r_hi   <= prod[63:32];
        r_lo   <= prod[31:0];
      end
      S_DIV: begin
        dv_q   <= dv_qf;
        dv_r   <= {1'b0, dv_rf};
        dv_cnt <= dv_cnt + 5'd1;
        if (dv_cnt == 5'd31) begin
          r_hilo <= 1'b1;
          r_lo   <= (dv_na != dv_nb) ? 32'd0 - dv_qf : dv_qf;
          r_hi   <= dv_na ? 32'd0 - dv_rf : dv_rf;
        end
      end
      S_MEM: begin
        if (cur.cls == CL_LOAD) begin
          r_wr  <= 1'b1;
          r_val <= ld_v;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> state == S_IDLE) else $error("item started during memory clear");
  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    gpr_we |-> r_idx != 5'd0) else $error("write to register zero");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dv_d != 32'd0) else $error("divider running on zero divisor");
  a_err_no_update: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && r_st != ST_OK |-> !r_hilo && !gpr_we)
    else $error("failed item updates state");
`endif
endmodule
